// File: sv/one_wire_pulse_width_cmd_tx_unit_defines.svh
// Assertion macros used by owpt_core.
// Both expect signals named clk and rst in the scope of use.
`ifndef ONE_WIRE_PULSE_WIDTH_CMD_TX_UNIT_DEFINES_SVH
`define ONE_WIRE_PULSE_WIDTH_CMD_TX_UNIT_DEFINES_SVH

`ifndef SYNTH
`define OWPT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("owpt check failed");
`define OWPT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("owpt check failed");
`else
`define OWPT_ASSERT_NOW(lbl, pre, post)
`define OWPT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: sv/owpt_pkg.sv
package owpt_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes, paddr[3:2]
  localparam logic [1:0] REG_START_LOW = 2'd0;
  localparam logic [1:0] REG_LONG      = 2'd1;
  localparam logic [1:0] REG_SHORT     = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  localparam logic [12:0] START_LOW_RST = 13'd5000;
  localparam logic [11:0] LONG_RST      = 12'd1200;
  localparam logic [11:0] SHORT_RST     = 12'd400;
  localparam logic [11:0] TIMEOUT_RST   = 12'd2000;

  typedef struct packed {
    logic       action;
    logic [7:0] cmd_byte;
    logic       busy_level;
  } in_t;

  typedef struct packed {
    logic data_line;
    logic idle;
    logic done_res;
    logic timed_out;
    logic rejected;
  } out_t;

  typedef struct packed {
    logic [12:0] start_low_ticks;
    logic [11:0] long_ticks;
    logic [11:0] short_ticks;
    logic [11:0] busy_timeout_ticks;
  } cfg_t;

endpackage

// File: sv/owpt_apb_regs.sv
module owpt_apb_regs
  import owpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks    <= START_LOW_RST;
      cfg.long_ticks         <= LONG_RST;
      cfg.short_ticks        <= SHORT_RST;
      cfg.busy_timeout_ticks <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_START_LOW: cfg.start_low_ticks    <= pwdata[12:0];
        REG_LONG:      cfg.long_ticks         <= pwdata[11:0];
        REG_SHORT:     cfg.short_ticks        <= pwdata[11:0];
        REG_TIMEOUT:   cfg.busy_timeout_ticks <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_LOW: prdata = {{(DATA_W-13){1'b0}}, cfg.start_low_ticks};
      REG_LONG:      prdata = {{(DATA_W-12){1'b0}}, cfg.long_ticks};
      REG_SHORT:     prdata = {{(DATA_W-12){1'b0}}, cfg.short_ticks};
      REG_TIMEOUT:   prdata = {{(DATA_W-12){1'b0}}, cfg.busy_timeout_ticks};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: sv/owpt_core.sv
`include "one_wire_pulse_width_cmd_tx_unit_defines.svh"

module owpt_core
  import owpt_pkg::*;
#(
  parameter int BITS_PER_FRAME = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  in_t  req,
  input  cfg_t cfg,
  output out_t res
);

  localparam int BL_W = (BITS_PER_FRAME > 1) ? $clog2(BITS_PER_FRAME) : 1;
  localparam logic [BL_W-1:0] BITS_LAST = BL_W'(BITS_PER_FRAME - 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_WAIT  = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [12:0] tick_count, tick_count_next;
  logic [7:0]  shift_bits, shift_bits_next;
  logic [BL_W-1:0] bits_left, bits_left_next;
  logic        line_level, line_level_next;

  logic [12:0] tick_inc;
  logic [11:0] high_len, low_len;
  logic        done, tout, rej;

  assign tick_inc = tick_count + 13'd1;
  // a one is long high / short low, a zero the reverse
  assign high_len = shift_bits[0] ? cfg.long_ticks  : cfg.short_ticks;
  assign low_len  = shift_bits[0] ? cfg.short_ticks : cfg.long_ticks;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    shift_bits_next = shift_bits;
    bits_left_next  = bits_left;
    line_level_next = line_level;
    done = 1'b0;
    tout = 1'b0;
    rej  = 1'b0;
    if (req.action) begin
      if (phase == PH_IDLE) begin
        shift_bits_next = req.cmd_byte;
        bits_left_next  = BITS_LAST;
        tick_count_next = '0;
        line_level_next = 1'b0;
        phase_next      = PH_START;
      end else begin
        rej = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_START: begin
          tick_count_next = tick_inc;
          if (tick_inc >= cfg.start_low_ticks) begin
            tick_count_next = '0;
            line_level_next = 1'b1;
            phase_next      = PH_HIGH;
          end
        end
        PH_HIGH: begin
          tick_count_next = tick_inc;
          if (tick_inc >= {1'b0, high_len}) begin
            tick_count_next = '0;
            line_level_next = 1'b0;
            phase_next      = PH_LOW;
          end
        end
        PH_LOW: begin
          tick_count_next = tick_inc;
          if (tick_inc >= {1'b0, low_len}) begin
            tick_count_next = '0;
            line_level_next = 1'b1;
            shift_bits_next = {1'b0, shift_bits[7:1]};
            if (bits_left == '0) begin
              phase_next = PH_WAIT;
            end else begin
              bits_left_next = bits_left - BL_W'(1);
              phase_next     = PH_HIGH;
            end
          end
        end
        PH_WAIT: begin
          if (!req.busy_level) begin
            done = 1'b1;
          end else if (tick_count >= {1'b0, cfg.busy_timeout_ticks}) begin
            done = 1'b1;
            tout = 1'b1;
          end else begin
            tick_count_next = tick_inc;
          end
          if (done) begin
            tick_count_next = '0;
            line_level_next = 1'b1;
            phase_next      = PH_IDLE;
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          line_level_next = 1'b1;
        end
      endcase
    end
  end

  assign res.data_line = line_level_next;
  assign res.idle      = (phase_next == PH_IDLE);
  assign res.done_res  = done;
  assign res.timed_out = tout;
  assign res.rejected  = rej;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      shift_bits <= '0;
      bits_left  <= '0;
      line_level <= 1'b1;
    end else if (fire) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      shift_bits <= shift_bits_next;
      bits_left  <= bits_left_next;
      line_level <= line_level_next;
    end
  end

  `OWPT_ASSERT_NOW(a_wait_line_high, phase == PH_WAIT || phase == PH_IDLE, line_level)
  `OWPT_ASSERT_NEXT(a_send_loads, fire && req.action && phase == PH_IDLE,
                    phase == PH_START && !line_level && bits_left == BITS_LAST)
  `OWPT_ASSERT_NEXT(a_reject_holds, fire && req.action && phase != PH_IDLE,
                    phase == $past(phase) && tick_count == $past(tick_count))
  `OWPT_ASSERT_NEXT(a_done_to_idle, fire && done, phase == PH_IDLE && tick_count == '0)

endmodule

// File: sv/owpt_out_reg.sv
module owpt_out_reg
  import owpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  out_t res,
  output logic hold_ok,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // take a new result when empty or when the held one leaves this cycle
  assign hold_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_ok) begin
      out_valid <= fire;
    end
    if (fire) begin
      out_data <= res;
    end
  end

endmodule

// File: sv/one_wire_pulse_width_cmd_tx_unit.sv
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the
// output register refills in the same cycle its held result is taken.
// Reset (rst, synchronous, active high): idle phase, counters cleared,
// line high, no result held, registers back to their default timings.
module one_wire_pulse_width_cmd_tx_unit
  import owpt_pkg::*;
#(
  parameter int BITS_PER_FRAME = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  out_t res;
  logic fire;

  assign fire = in_valid && in_ready;

  owpt_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owpt_core #(
    .BITS_PER_FRAME (BITS_PER_FRAME)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (in_data),
    .cfg  (cfg),
    .res  (res)
  );

  owpt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .hold_ok   (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
